// File: rtl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types, constants and helpers of the buddy page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

	localparam int TOP_ORDER  = 10;
	localparam int PAGE_W     = TOP_ORDER;
	localparam int LINK_W     = TOP_ORDER + 1;
	localparam int ORD_W      = 4;
	localparam int CNT_W      = 11;
	localparam int POOL_PAGES = 1 << TOP_ORDER;

	localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_PAGES);

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOSPACE = 2'd1;
	localparam logic [1:0] ST_BAD     = 2'd2;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [CNT_W-1:0]  page_count;
		logic [PAGE_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] result_index;
		logic [CNT_W-1:0]  pages_avail;
	} rsp_t;

	typedef struct packed {
		logic [PAGE_W-1:0] raddr;
		logic [ORD_W-1:0]  head_idx;
		logic              head_we;
		logic [LINK_W-1:0] head_wdata;
		logic              head_init;
		logic [ORD_W-1:0]  init_order;
		logic              mark_we;
		logic [PAGE_W-1:0] mark_addr;
		logic              mark_wdata;
		logic              ord_we;
		logic [PAGE_W-1:0] ord_addr;
		logic [ORD_W-1:0]  ord_wdata;
		logic              nxt_we;
		logic [PAGE_W-1:0] nxt_addr;
		logic [LINK_W-1:0] nxt_wdata;
		logic              prv_we;
		logic [PAGE_W-1:0] prv_addr;
		logic [LINK_W-1:0] prv_wdata;
	} store_cmd_t;

	typedef struct packed {
		logic              mark_rd;
		logic [ORD_W-1:0]  ord_rd;
		logic [LINK_W-1:0] nxt_rd;
		logic [LINK_W-1:0] prv_rd;
		logic [LINK_W-1:0] head_rd;
	} store_sts_t;

	// smallest k with 2^k >= cnt, zero for cnt of 0 or 1
	function automatic logic [ORD_W-1:0] round_order(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] c1;
		logic [ORD_W-1:0] k;
		c1 = cnt - CNT_W'(1);
		k  = '0;
		for (int b = 0; b < CNT_W; b++) begin
			if (c1[b]) k = ORD_W'(b + 1);
		end
		if (cnt == '0) k = '0;
		return k;
	endfunction

endpackage
`default_nettype wire

// File: rtl/bpa_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_store
// per-page memories (free mark, order, links) and the free list heads
// ----------------------------------------------------------------------------
module bpa_store (
	input  wire                     clk,
	input  wire                     arst_n,
	input  bpa_pkg::store_cmd_t     cmd,
	output bpa_pkg::store_sts_t     sts
);

	logic                          mark_mem [bpa_pkg::POOL_PAGES];
	logic [bpa_pkg::ORD_W-1:0]     ord_mem  [bpa_pkg::POOL_PAGES];
	logic [bpa_pkg::LINK_W-1:0]    nxt_mem  [bpa_pkg::POOL_PAGES];
	logic [bpa_pkg::LINK_W-1:0]    prv_mem  [bpa_pkg::POOL_PAGES];
	logic [bpa_pkg::LINK_W-1:0]    head_q   [bpa_pkg::TOP_ORDER+1];

	logic                          mark_rd_q;
	logic [bpa_pkg::ORD_W-1:0]     ord_rd_q;
	logic [bpa_pkg::LINK_W-1:0]    nxt_rd_q;
	logic [bpa_pkg::LINK_W-1:0]    prv_rd_q;

	always_ff @(posedge clk) begin
		if (cmd.mark_we) mark_mem[cmd.mark_addr] <= cmd.mark_wdata;
		if (cmd.ord_we)  ord_mem[cmd.ord_addr]   <= cmd.ord_wdata;
		if (cmd.nxt_we)  nxt_mem[cmd.nxt_addr]   <= cmd.nxt_wdata;
		if (cmd.prv_we)  prv_mem[cmd.prv_addr]   <= cmd.prv_wdata;
		mark_rd_q <= mark_mem[cmd.raddr];
		ord_rd_q  <= ord_mem[cmd.raddr];
		nxt_rd_q  <= nxt_mem[cmd.raddr];
		prv_rd_q  <= prv_mem[cmd.raddr];
	end

	// list heads, reinit puts the whole pool on one list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int o = 0; o <= bpa_pkg::TOP_ORDER; o++) begin
				head_q[o] <= (o == bpa_pkg::TOP_ORDER) ? '0 : bpa_pkg::NIL_LINK;
			end
		end else if (cmd.head_init) begin
			for (int o = 0; o <= bpa_pkg::TOP_ORDER; o++) begin
				head_q[o] <= (bpa_pkg::ORD_W'(o) == cmd.init_order) ? '0 : bpa_pkg::NIL_LINK;
			end
		end else if (cmd.head_we) begin
			head_q[cmd.head_idx] <= cmd.head_wdata;
		end
	end

	assign sts.mark_rd = mark_rd_q;
	assign sts.ord_rd  = ord_rd_q;
	assign sts.nxt_rd  = nxt_rd_q;
	assign sts.prv_rd  = prv_rd_q;
	assign sts.head_rd = (cmd.head_idx <= bpa_pkg::ORD_W'(bpa_pkg::TOP_ORDER)) ?
		head_q[cmd.head_idx] : bpa_pkg::NIL_LINK;

endmodule
`default_nettype wire

// File: rtl/bpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl
// request sequencer: search, split, merge and list maintenance
// ----------------------------------------------------------------------------
module bpa_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [bpa_pkg::ORD_W-1:0]     cfg_wdata,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  bpa_pkg::req_t                in_data,
	output logic                         res_valid,
	input  wire                          res_free,
	output bpa_pkg::rsp_t                res,
	output bpa_pkg::store_cmd_t          cmd,
	input  bpa_pkg::store_sts_t          sts
);

	typedef enum logic [4:0] {
		S_CLEAR, S_INIT, S_IDLE, S_A_SEARCH, S_A_SUL, S_A_FUL,
		S_PA, S_PB, S_F_CHK, S_F_MCHK, S_F_UC, S_F_RB, S_F_UB, S_DONE
	} state_t;

	typedef enum logic [1:0] { R_SPLIT_LO, R_SPLIT_NEXT, R_MERGE } ret_t;

	localparam int PW = bpa_pkg::PAGE_W;
	localparam int OW = bpa_pkg::ORD_W;
	localparam int CW = bpa_pkg::CNT_W;
	localparam int LW = bpa_pkg::LINK_W;

	state_t          state_q;
	ret_t            ret_q;
	logic [PW-1:0]   clr_q;
	logic [OW-1:0]   pool_q;
	logic [CW-1:0]   cnt_q;
	logic [OW-1:0]   k_q;
	logic [OW-1:0]   i_q;
	logic [OW-1:0]   po_q;
	logic [OW-1:0]   size_ord_q;
	logic [PW-1:0]   blk_q;
	logic [PW-1:0]   bud_q;
	logic [PW-1:0]   pb_q;
	logic [1:0]      st_q;
	logic [PW-1:0]   res_idx_q;

	logic [OW-1:0]   k_in;
	logic [OW-1:0]   cfg_sat;
	logic [CW:0]     pool_pages;
	logic [PW-1:0]   bud_next;
	logic [OW-1:0]   ord_rd;
	logic [PW-1:0]   ord_mask;
	logic [CW:0]     free_sum;
	logic            accept;

	assign k_in       = bpa_pkg::round_order(in_data.page_count);
	assign cfg_sat    = (cfg_wdata > OW'(bpa_pkg::TOP_ORDER)) ? OW'(bpa_pkg::TOP_ORDER) : cfg_wdata;
	assign pool_pages = (CW+1)'(1) << pool_q;
	assign bud_next   = blk_q ^ (PW'(1) << po_q);
	assign ord_rd     = sts.ord_rd;
	assign ord_mask   = PW'((CW'(1) << ord_rd) - CW'(1));
	assign free_sum   = {1'b0, cnt_q} + {1'b0, CW'(1) << ord_rd};
	assign in_stall   = (state_q != S_IDLE);
	assign accept     = in_valid && (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);

	assign res.status       = st_q;
	assign res.result_index = res_idx_q;
	assign res.pages_avail  = cnt_q;

	// store commands
	always_comb begin
		cmd            = '0;
		cmd.raddr      = blk_q;
		cmd.head_idx   = i_q;
		cmd.head_init  = cfg_we;
		cmd.init_order = cfg_sat;
		unique case (state_q)
			S_CLEAR: begin
				cmd.mark_we   = 1'b1;
				cmd.mark_addr = clr_q;
			end
			S_INIT: begin
				cmd.mark_we    = 1'b1;
				cmd.mark_wdata = 1'b1;
				cmd.ord_we     = 1'b1;
				cmd.ord_wdata  = pool_q;
				cmd.nxt_we     = 1'b1;
				cmd.nxt_wdata  = bpa_pkg::NIL_LINK;
				cmd.prv_we     = 1'b1;
				cmd.prv_wdata  = bpa_pkg::NIL_LINK;
			end
			S_IDLE: cmd.raddr = in_data.block_index;
			S_A_SEARCH: cmd.raddr = sts.head_rd[PW-1:0];
			S_A_SUL, S_A_FUL, S_F_UC: begin
				// unlink a list head
				cmd.head_we    = 1'b1;
				cmd.head_wdata = sts.nxt_rd;
				cmd.prv_we     = !sts.nxt_rd[LW-1];
				cmd.prv_addr   = sts.nxt_rd[PW-1:0];
				cmd.prv_wdata  = bpa_pkg::NIL_LINK;
				cmd.mark_we    = 1'b1;
				cmd.mark_addr  = blk_q;
			end
			S_PA: begin
				cmd.head_idx   = po_q;
				cmd.nxt_we     = 1'b1;
				cmd.nxt_addr   = pb_q;
				cmd.nxt_wdata  = sts.head_rd;
				cmd.mark_we    = 1'b1;
				cmd.mark_addr  = pb_q;
				cmd.mark_wdata = 1'b1;
				cmd.ord_we     = 1'b1;
				cmd.ord_addr   = pb_q;
				cmd.ord_wdata  = po_q;
				cmd.prv_we     = !sts.head_rd[LW-1];
				cmd.prv_addr   = sts.head_rd[PW-1:0];
				cmd.prv_wdata  = {1'b0, pb_q};
				cmd.head_we    = 1'b1;
				cmd.head_wdata = {1'b0, pb_q};
			end
			S_PB: begin
				cmd.prv_we    = 1'b1;
				cmd.prv_addr  = pb_q;
				cmd.prv_wdata = bpa_pkg::NIL_LINK;
				cmd.raddr     = (ret_q == R_MERGE) ? bud_next : blk_q;
			end
			S_F_RB: cmd.raddr = bud_q;
			S_F_UB: begin
				// unlink anywhere in the list
				cmd.nxt_we     = !sts.prv_rd[LW-1];
				cmd.nxt_addr   = sts.prv_rd[PW-1:0];
				cmd.nxt_wdata  = sts.nxt_rd;
				cmd.head_we    = sts.prv_rd[LW-1];
				cmd.head_wdata = sts.nxt_rd;
				cmd.prv_we     = !sts.nxt_rd[LW-1];
				cmd.prv_addr   = sts.nxt_rd[PW-1:0];
				cmd.prv_wdata  = sts.prv_rd;
				cmd.mark_we    = 1'b1;
				cmd.mark_addr  = bud_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			ret_q      <= R_SPLIT_LO;
			clr_q      <= '0;
			pool_q     <= OW'(bpa_pkg::TOP_ORDER);
			cnt_q      <= CW'(bpa_pkg::POOL_PAGES);
			k_q        <= '0;
			i_q        <= '0;
			po_q       <= '0;
			size_ord_q <= '0;
			blk_q      <= '0;
			bud_q      <= '0;
			pb_q       <= '0;
			st_q       <= bpa_pkg::ST_OK;
			res_idx_q  <= '0;
		end else if (cfg_we) begin
			pool_q  <= cfg_sat;
			cnt_q   <= CW'(1) << cfg_sat;
			clr_q   <= '0;
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + PW'(1);
					if (&clr_q) state_q <= S_INIT;
				end
				S_INIT: state_q <= S_IDLE;
				S_IDLE: begin
					if (accept) begin
						k_q       <= k_in;
						i_q       <= k_in;
						blk_q     <= in_data.block_index;
						res_idx_q <= '0;
						if (in_data.page_count == '0) begin
							st_q    <= bpa_pkg::ST_BAD;
							state_q <= S_DONE;
						end else if (in_data.req_type == bpa_pkg::REQ_ALLOC) begin
							if (in_data.page_count > cnt_q || k_in > pool_q) begin
								st_q    <= bpa_pkg::ST_NOSPACE;
								state_q <= S_DONE;
							end else begin
								st_q    <= bpa_pkg::ST_OK;
								state_q <= S_A_SEARCH;
							end
						end else if ({2'b00, in_data.block_index} >= pool_pages) begin
							st_q    <= bpa_pkg::ST_BAD;
							state_q <= S_DONE;
						end else begin
							st_q    <= bpa_pkg::ST_OK;
							state_q <= S_F_CHK;
						end
					end
				end
				S_A_SEARCH: begin
					if (i_q > pool_q) begin
						st_q    <= bpa_pkg::ST_NOSPACE;
						state_q <= S_DONE;
					end else if (!sts.head_rd[LW-1]) begin
						blk_q   <= sts.head_rd[PW-1:0];
						state_q <= (i_q == k_q) ? S_A_FUL : S_A_SUL;
					end else begin
						i_q <= i_q + OW'(1);
					end
				end
				S_A_SUL: begin
					pb_q    <= blk_q + (PW'(1) << (i_q - OW'(1)));
					po_q    <= i_q - OW'(1);
					ret_q   <= R_SPLIT_LO;
					state_q <= S_PA;
				end
				S_A_FUL: begin
					cnt_q     <= cnt_q - (CW'(1) << k_q);
					res_idx_q <= blk_q;
					state_q   <= S_DONE;
				end
				S_PA: state_q <= S_PB;
				S_PB: begin
					unique case (ret_q)
						R_SPLIT_LO: begin
							pb_q    <= blk_q;
							ret_q   <= R_SPLIT_NEXT;
							state_q <= S_PA;
						end
						R_SPLIT_NEXT: begin
							i_q     <= po_q;
							state_q <= (po_q == k_q) ? S_A_FUL : S_A_SUL;
						end
						R_MERGE: begin
							i_q <= po_q;
							if (po_q >= pool_q) begin
								cnt_q   <= cnt_q + (CW'(1) << size_ord_q);
								state_q <= S_DONE;
							end else begin
								bud_q   <= bud_next;
								state_q <= S_F_MCHK;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_F_CHK: begin
					if (ord_rd > pool_q || ord_rd != k_q || (blk_q & ord_mask) != '0 ||
						sts.mark_rd || free_sum > pool_pages) begin
						st_q    <= bpa_pkg::ST_BAD;
						state_q <= S_DONE;
					end else begin
						size_ord_q <= ord_rd;
						pb_q       <= blk_q;
						po_q       <= ord_rd;
						ret_q      <= R_MERGE;
						state_q    <= S_PA;
					end
				end
				S_F_MCHK: begin
					if (!sts.mark_rd || ord_rd != i_q) begin
						cnt_q   <= cnt_q + (CW'(1) << size_ord_q);
						state_q <= S_DONE;
					end else begin
						state_q <= S_F_UC;
					end
				end
				S_F_UC: state_q <= S_F_RB;
				S_F_RB: state_q <= S_F_UB;
				S_F_UB: begin
					blk_q   <= blk_q & ~(PW'(1) << i_q);
					pb_q    <= blk_q & ~(PW'(1) << i_q);
					po_q    <= i_q + OW'(1);
					ret_q   <= R_MERGE;
					state_q <= S_PA;
				end
				S_DONE: begin
					if (res_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: rtl/buddy_page_allocator_top.sv
`timescale 1ns / 1ps
`default_nettype none
// allocate searches the free lists upward from the rounded order, then splits down one level at a time
// free checks the block, then merges with its free buddy one order at a time up to the pool top
// requests rejected at acceptance, or a free rejected by its page checks, go straight to the result
// one request at a time, next transfer taken when the sequencer is back in idle
// the link memories (one write port each) make every split or merge level a sequence of states
// after reset or a pool_order write, a sweep clears the free marks, input stalled
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// buddy page allocator with one free list per order
// ----------------------------------------------------------------------------
module buddy_page_allocator_top (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire [bpa_pkg::ORD_W-1:0]     cfg_wdata,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  bpa_pkg::req_t                in_data,
	output logic                         out_valid,
	input  wire                          out_stall,
	output bpa_pkg::rsp_t                out_data
);

	bpa_pkg::store_cmd_t cmd;
	bpa_pkg::store_sts_t sts;
	bpa_pkg::rsp_t       res;
	logic                res_valid;
	logic                res_free;
	logic                out_valid_q;
	bpa_pkg::rsp_t       out_data_q;

	// sequencer: owns pool size, free count and request flow
	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.res_valid (res_valid),
		.res_free  (res_free),
		.res       (res),
		.cmd       (cmd),
		.sts       (sts)
	);

	// page memories and list heads
	bpa_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.sts    (sts)
	);

	// output register, frees up as soon as its transfer completes
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (res_valid && res_free) begin
			out_valid_q <= 1'b1;
			out_data_q  <= res;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTHESIS
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == bpa_pkg::ST_OK ||
			out_data.status == bpa_pkg::ST_NOSPACE || out_data.status == bpa_pkg::ST_BAD))
		else $error("status code out of range");
	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != bpa_pkg::ST_OK |-> out_data.result_index == '0)
		else $error("failed request returned nonzero index");
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.pages_avail <= bpa_pkg::CNT_W'(bpa_pkg::POOL_PAGES))
		else $error("free page count above pool size");
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> in_stall)
		else $error("input taken during reinit sweep");
`endif

endmodule
`default_nettype wire
